// ===== rtl/efe_pkg.sv =====
// ----------------------------------------------------------------------------
// efe_pkg - shared types and constants of the eased fade envelope
// Widths, command codes, state encodings and register indexes.
// ----------------------------------------------------------------------------
package efe_pkg;

  // timer width and derived widths
  localparam int TIME_BITS = 24;
  localparam int CFG_W     = 24;
  localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int SUM_W     = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
  localparam int DELTA_W   = 16;
  localparam int ACTION_W  = 3;
  localparam int WGT_W     = 17;
  localparam int EB_W      = 2;

  // serial divider: 16 quotient bits, one per cycle
  localparam int DIV_STEPS = 16;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // command queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // APB
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_W-1:0]     cfgv_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [DELTA_W-1:0]   delta_t;
  typedef logic [ACTION_W-1:0]  action_t;
  typedef logic [WGT_W-1:0]     wgt_t;
  typedef logic [EB_W-1:0]      eb_t;
  typedef logic [31:0]          sq_t;
  typedef logic [2*WGT_W-1:0]   prod_t;

  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};
  localparam wgt_t  FULL_W   = wgt_t'(65536);
  localparam wgt_t  HALF_W   = wgt_t'(32768);

  // raw action codes on the input channel
  localparam action_t ACT_TICK   = 3'd0;
  localparam action_t ACT_ON     = 3'd1;
  localparam action_t ACT_OFF    = 3'd2;
  localparam action_t ACT_PAUSE  = 3'd3;
  localparam action_t ACT_RESUME = 3'd4;

  // end behaviour codes
  localparam eb_t EB_BLEND = 2'd0;
  localparam eb_t EB_END   = 2'd1;

  // register indexes (byte address 4*i)
  localparam logic [1:0] REG_BLEND_IN  = 2'd0;
  localparam logic [1:0] REG_BLEND_OUT = 2'd1;
  localparam logic [1:0] REG_DURATION  = 2'd2;
  localparam logic [1:0] REG_END_BEH   = 2'd3;

  // decoded command
  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_ACTIVATE,
    OP_DEACTIVATE,
    OP_PAUSE,
    OP_RESUME
  } op_t;

  typedef struct packed {
    op_t    op;
    delta_t delta;
  } cmd_t;

  typedef struct packed {
    cfgv_t blend_in;
    cfgv_t blend_out;
    cfgv_t duration;
    eb_t   end_beh;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SQR,
    S_EASE,
    S_SCALE,
    S_DONE
  } bstate_t;

endpackage

// ===== rtl/efe_if.sv =====
// ----------------------------------------------------------------------------
// efe_if - item channels of the eased fade envelope
// Valid/ready channels for commands in and envelope results out.
// ----------------------------------------------------------------------------
interface efe_in_if;
  logic              valid;
  logic              ready;
  efe_pkg::action_t  action;
  efe_pkg::delta_t   delta_time;

  modport source (output valid, action, delta_time, input ready);
  modport sink   (input valid, action, delta_time, output ready);
endinterface

interface efe_out_if;
  logic          valid;
  logic          ready;
  efe_pkg::wgt_t weight;
  logic          is_active;
  logic          is_exiting;
  logic          is_paused;

  modport source (output valid, weight, is_active, is_exiting, is_paused, input ready);
  modport sink   (input valid, weight, is_active, is_exiting, is_paused, output ready);
endinterface

// ===== rtl/efe_front.sv =====
// ----------------------------------------------------------------------------
// efe_front - command intake
// Accepts items while the queue has room and decodes the action code.
// ----------------------------------------------------------------------------
module efe_front (
  efe_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output efe_pkg::cmd_t q_cmd
);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_cmd.delta = in_ch.delta_time;
    unique case (in_ch.action)
      efe_pkg::ACT_TICK:   q_cmd.op = efe_pkg::OP_TICK;
      efe_pkg::ACT_ON:     q_cmd.op = efe_pkg::OP_ACTIVATE;
      efe_pkg::ACT_OFF:    q_cmd.op = efe_pkg::OP_DEACTIVATE;
      efe_pkg::ACT_PAUSE:  q_cmd.op = efe_pkg::OP_PAUSE;
      efe_pkg::ACT_RESUME: q_cmd.op = efe_pkg::OP_RESUME;
      default:             q_cmd.op = efe_pkg::OP_NOP; // unused codes
    endcase
  end

endmodule

// ===== rtl/efe_fifo.sv =====
// ----------------------------------------------------------------------------
// efe_fifo - command queue
// Small register FIFO between intake and execution.
// ----------------------------------------------------------------------------
module efe_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  efe_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output efe_pkg::cmd_t q_cmd
);

  efe_pkg::cmd_t                 mem_r [efe_pkg::QDEPTH];
  logic [efe_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [efe_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [efe_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_pop;

  assign full    = (cnt_r == efe_pkg::QCNT_W'(efe_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == efe_pkg::QPTR_W'(efe_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == efe_pkg::QPTR_W'(efe_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/efe_div.sv =====
// ----------------------------------------------------------------------------
// efe_div - serial ratio divider
// Restoring divide giving floor(num * 65536 / den), one bit per cycle.
// Valid only for num < den; the caller clamps otherwise.
// ----------------------------------------------------------------------------
module efe_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  efe_pkg::cmp_t num,
  input  efe_pkg::cmp_t den,
  output logic          done,
  output logic [15:0]   quo
);

  efe_pkg::cmp_t              rem_r, rem_nxt;
  efe_pkg::cmp_t              den_r, den_nxt;
  logic [15:0]                quo_r, quo_nxt;
  logic [efe_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [efe_pkg::CMP_W:0]    rem2;
  logic [efe_pkg::CMP_W:0]    diff;

  assign done = done_r;
  assign quo  = quo_r;
  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_nxt = diff[efe_pkg::CMP_W-1:0];
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = rem2[efe_pkg::CMP_W-1:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == efe_pkg::DCNT_W'(efe_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

endmodule

// ===== rtl/efe_back.sv =====
// ----------------------------------------------------------------------------
// efe_back - envelope execution
// Holds the envelope state, runs ticks through divide, ease and scale
// steps and drives the result register.
// ----------------------------------------------------------------------------
module efe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  efe_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  efe_pkg::cmd_t q_cmd,
  output logic          q_pop,
  efe_out_if.source     out_ch
);

  efe_pkg::bstate_t state_r, state_nxt;

  efe_pkg::time_t elapsed_r, elapsed_nxt;
  efe_pkg::wgt_t  weight_r, weight_nxt;
  efe_pkg::wgt_t  fsw_r, fsw_nxt;
  logic           active_r, active_nxt;
  logic           exiting_r, exiting_nxt;
  logic           paused_r, paused_nxt;

  // datapath registers
  logic           ge_r, ge_nxt;
  efe_pkg::wgt_t  a_r, a_nxt;
  efe_pkg::sq_t   sq_r, sq_nxt;
  logic           hi_r, hi_nxt;
  efe_pkg::wgt_t  om_r, om_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  efe_pkg::wgt_t  out_weight_r;
  logic           out_active_r, out_exiting_r, out_paused_r;
  logic           load;

  // tick helpers
  efe_pkg::sum_t  t_sum;
  efe_pkg::time_t t_sat;
  efe_pkg::time_t t_new;
  logic           exit_new;
  logic           dur_hit;
  efe_pkg::cmp_t  span;
  efe_pkg::wgt_t  r_val;
  efe_pkg::wgt_t  e_val;
  efe_pkg::prod_t prod;

  logic           div_start;
  logic           div_done;
  logic [15:0]    div_quo;

  efe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (efe_pkg::cmp_t'(t_new)),
    .den   (span),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign t_sum = efe_pkg::sum_t'(elapsed_r) + efe_pkg::sum_t'(q_cmd.delta);
  assign t_sat = (t_sum > efe_pkg::sum_t'(efe_pkg::TIME_MAX)) ? efe_pkg::TIME_MAX :
                 efe_pkg::time_t'(t_sum);
  assign dur_hit = (cfg.duration != '0) && !exiting_r &&
                   (efe_pkg::cmp_t'(t_sat) >= efe_pkg::cmp_t'(cfg.duration));
  assign t_new    = dur_hit ? '0 : t_sat;
  assign exit_new = exiting_r || dur_hit;
  assign span     = exit_new ? efe_pkg::cmp_t'(cfg.blend_out) :
                    efe_pkg::cmp_t'(cfg.blend_in);

  assign r_val = efe_pkg::FULL_W - a_r;
  assign e_val = hi_r ? efe_pkg::FULL_W - efe_pkg::wgt_t'(sq_r >> 15) :
                 efe_pkg::wgt_t'(sq_r >> 15);
  assign prod  = efe_pkg::prod_t'(fsw_r) * efe_pkg::prod_t'(om_r);

  assign load = (state_r == efe_pkg::S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt   = state_r;
    elapsed_nxt = elapsed_r;
    weight_nxt  = weight_r;
    fsw_nxt     = fsw_r;
    active_nxt  = active_r;
    exiting_nxt = exiting_r;
    paused_nxt  = paused_r;
    ge_nxt      = ge_r;
    a_nxt       = a_r;
    sq_nxt      = sq_r;
    hi_nxt      = hi_r;
    om_nxt      = om_r;
    q_pop       = 1'b0;
    div_start   = 1'b0;
    unique case (state_r)
      efe_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = efe_pkg::S_DONE;
          unique case (q_cmd.op)
            efe_pkg::OP_TICK: begin
              if (active_r && !paused_r) begin
                elapsed_nxt = t_new;
                exiting_nxt = exit_new;
                if (dur_hit) begin
                  fsw_nxt = weight_r;
                end
                ge_nxt = (efe_pkg::cmp_t'(t_new) >= span);
                if (exit_new) begin
                  if (cfg.blend_out == '0) begin
                    weight_nxt = '0;
                  end else begin
                    div_start = 1'b1;
                    state_nxt = efe_pkg::S_DIV;
                  end
                end else if ((cfg.blend_in != '0) &&
                             (efe_pkg::cmp_t'(t_new) < span)) begin
                  div_start = 1'b1;
                  state_nxt = efe_pkg::S_DIV;
                end else begin
                  weight_nxt = efe_pkg::FULL_W;
                end
              end
            end
            efe_pkg::OP_ACTIVATE: begin
              elapsed_nxt = '0;
              active_nxt  = 1'b1;
              exiting_nxt = 1'b0;
              paused_nxt  = 1'b0;
              fsw_nxt     = efe_pkg::FULL_W;
              weight_nxt  = '0;
            end
            efe_pkg::OP_DEACTIVATE: begin
              if (active_r && (cfg.end_beh == efe_pkg::EB_BLEND)) begin
                fsw_nxt     = weight_r;
                exiting_nxt = 1'b1;
                elapsed_nxt = '0;
              end else if (active_r && (cfg.end_beh == efe_pkg::EB_END)) begin
                active_nxt  = 1'b0;
                exiting_nxt = 1'b0;
                weight_nxt  = '0;
                fsw_nxt     = efe_pkg::FULL_W;
              end
            end
            efe_pkg::OP_PAUSE:  paused_nxt = 1'b1;
            efe_pkg::OP_RESUME: paused_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      efe_pkg::S_DIV: begin
        if (div_done) begin
          a_nxt     = ge_r ? efe_pkg::FULL_W : efe_pkg::wgt_t'(div_quo);
          state_nxt = efe_pkg::S_SQR;
        end
      end
      efe_pkg::S_SQR: begin
        if (a_r < efe_pkg::HALF_W) begin
          sq_nxt = efe_pkg::sq_t'(a_r[14:0]) * efe_pkg::sq_t'(a_r[14:0]);
          hi_nxt = 1'b0;
        end else begin
          sq_nxt = efe_pkg::sq_t'(r_val[15:0]) * efe_pkg::sq_t'(r_val[15:0]);
          hi_nxt = 1'b1;
        end
        state_nxt = efe_pkg::S_EASE;
      end
      efe_pkg::S_EASE: begin
        if (exiting_r) begin
          om_nxt    = efe_pkg::FULL_W - e_val;
          state_nxt = efe_pkg::S_SCALE;
        end else begin
          weight_nxt = e_val;
          state_nxt  = efe_pkg::S_DONE;
        end
      end
      efe_pkg::S_SCALE: begin
        weight_nxt = prod[32:16];
        state_nxt  = efe_pkg::S_DONE;
      end
      efe_pkg::S_DONE: begin
        if (load) begin
          state_nxt = efe_pkg::S_IDLE;
        end
      end
      default: state_nxt = efe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= efe_pkg::S_IDLE;
      elapsed_r   <= '0;
      weight_r    <= '0;
      fsw_r       <= efe_pkg::FULL_W;
      active_r    <= 1'b0;
      exiting_r   <= 1'b0;
      paused_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      weight_r    <= weight_nxt;
      fsw_r       <= fsw_nxt;
      active_r    <= active_nxt;
      exiting_r   <= exiting_nxt;
      paused_r    <= paused_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ge_r <= ge_nxt;
    a_r  <= a_nxt;
    sq_r <= sq_nxt;
    hi_r <= hi_nxt;
    om_r <= om_nxt;
    if (load) begin
      out_weight_r  <= weight_r;
      out_active_r  <= active_r;
      out_exiting_r <= exiting_r;
      out_paused_r  <= paused_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.weight     = out_weight_r;
  assign out_ch.is_active  = out_active_r;
  assign out_ch.is_exiting = out_exiting_r;
  assign out_ch.is_paused  = out_paused_r;

`ifndef ASSERT_OFF
  a_exit_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    exiting_r |-> active_r)
    else $error("exiting set while not active");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    weight_r <= efe_pkg::FULL_W)
    else $error("weight above full scale");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == efe_pkg::S_DONE))
    else $error("result loaded outside done state");
`endif

endmodule

// ===== rtl/eased_fade_envelope_unit.sv =====
// ----------------------------------------------------------------------------
// eased_fade_envelope_unit - ease-in-out fade envelope
// Blend weight envelope with quadratic ease-in-out, driven by tick,
// activate, deactivate, pause and resume items.
// ----------------------------------------------------------------------------
//
//   channel  | direction | payload                                   | flow
//   ---------+-----------+-------------------------------------------+-----------
//   in_ch    | in        | action[2:0], delta_time[15:0]             | valid/ready
//   out_ch   | out       | weight[16:0], is_active, is_exiting,      | valid/ready
//            |           | is_paused                                 |
//   cfg_*    | in        | APB write/read, 4 registers at 4*i        | pready = 1
//
// Steps: an eased tick runs issue, 16 divider steps, quotient capture,
//   square, ease, scale in blend-out only, and result; the divider
//   yields one quotient bit per cycle.
//   Every other item goes straight from issue to result.
// Reset: synchronous, active low; clears queue, state and result register.
// Stalls: the two-entry queue keeps taking items while the back end works
//   or a result waits on out_ch; in_ch.ready drops only when the queue is full.
//
module eased_fade_envelope_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  efe_in_if.sink                       in_ch,
  efe_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [efe_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [efe_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [efe_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  // configuration registers
  efe_pkg::cfg_t cfg_r, cfg_nxt;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  // queue handshake
  logic          q_full;
  logic          q_push;
  efe_pkg::cmd_t push_cmd;
  logic          q_pop;
  logic          q_valid;
  efe_pkg::cmd_t q_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  // register write decode; values are masked to the field width
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        efe_pkg::REG_BLEND_IN:  cfg_nxt.blend_in  = cfg_pwdata[efe_pkg::CFG_W-1:0];
        efe_pkg::REG_BLEND_OUT: cfg_nxt.blend_out = cfg_pwdata[efe_pkg::CFG_W-1:0];
        efe_pkg::REG_DURATION:  cfg_nxt.duration  = cfg_pwdata[efe_pkg::CFG_W-1:0];
        efe_pkg::REG_END_BEH:   cfg_nxt.end_beh   = cfg_pwdata[efe_pkg::EB_W-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (cfg_idx)
      efe_pkg::REG_BLEND_IN:  cfg_prdata = efe_pkg::APB_DW'(cfg_r.blend_in);
      efe_pkg::REG_BLEND_OUT: cfg_prdata = efe_pkg::APB_DW'(cfg_r.blend_out);
      efe_pkg::REG_DURATION:  cfg_prdata = efe_pkg::APB_DW'(cfg_r.duration);
      efe_pkg::REG_END_BEH:   cfg_prdata = efe_pkg::APB_DW'(cfg_r.end_beh);
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: intake and decode
  efe_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  // queue between front and back
  efe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // back: envelope state, easing datapath and result register
  efe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/sv/tb_eased_fade_envelope_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_eased_fade_envelope_unit - self-checking bench for the fade envelope
// Drives tick, activate, deactivate, pause and resume items through the
// input channel, programs the four registers over APB, and compares each
// result item against a cycle-free envelope predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_eased_fade_envelope_unit;

  // expected content of one result item
  typedef struct packed {
    efe_pkg::wgt_t weight;
    logic          active;
    logic          exiting;
    logic          paused;
  } envelope_t;

  // codes the package leaves unnamed
  localparam efe_pkg::action_t ACT_SPARE_FIRST = 3'd5;
  localparam efe_pkg::action_t ACT_SPARE_LAST  = 3'd7;
  localparam efe_pkg::eb_t     EB_STAY         = 2'd2;
  localparam efe_pkg::eb_t     EB_SPARE        = 2'd3;

  localparam efe_pkg::cfgv_t  CFG_MAX      = '1;
  localparam efe_pkg::delta_t DELTA_MAX    = '1;
  localparam int              MAX_REPORTS  = 10;
  // settle a little longer than the longest eased tick takes
  localparam int              DRAIN_SETTLE = 24;

  logic clk = 1'b0;
  logic rst_n;

  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [efe_pkg::APB_AW-1:0]   cfg_paddr;
  logic [efe_pkg::APB_DW-1:0]   cfg_pwdata;
  logic [efe_pkg::APB_DW-1:0]   cfg_prdata;
  logic                         cfg_pready;

  efe_in_if  in_ch ();
  efe_out_if out_ch ();

  // result side ready, driven only by the checker process
  logic sink_ready = 1'b0;
  assign out_ch.ready = sink_ready;

  always #5 clk = ~clk;

  eased_fade_envelope_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Envelope predictor: its own copy of the state and the register file
  // --------------------------------------------------------------------------
  longint unsigned env_elapsed;
  efe_pkg::wgt_t   env_weight;
  efe_pkg::wgt_t   env_fade_from;
  bit              env_active;
  bit              env_exiting;
  bit              env_paused;

  efe_pkg::cfgv_t len_in;      // blend-in length
  efe_pkg::cfgv_t len_out;     // blend-out length
  efe_pkg::cfgv_t len_run;     // active duration, zero = unlimited
  efe_pkg::eb_t   on_release;  // what deactivate does

  envelope_t   expected_envelope[$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned settings_used;
  int unsigned sink_hold;
  bit          idling = 1'b1;
  envelope_t   due;

  function automatic void reset_envelope_model();
    env_elapsed   = 0;
    env_weight    = '0;
    env_fade_from = efe_pkg::FULL_W;
    env_active    = 1'b0;
    env_exiting   = 1'b0;
    env_paused    = 1'b0;
    len_in        = '0;
    len_out       = '0;
    len_run       = '0;
    on_release    = efe_pkg::EB_BLEND;
  endfunction

  // quadratic ease-in-out of t/span in Q1.16, ratio clamped to one
  function automatic efe_pkg::wgt_t eased_fraction(longint unsigned t,
                                                   longint unsigned span);
    longint unsigned frac;
    longint unsigned rest;
    frac = (t << 16) / span;
    if (frac > efe_pkg::FULL_W) frac = 64'(efe_pkg::FULL_W);
    if (frac < efe_pkg::HALF_W) return efe_pkg::wgt_t'((frac * frac) >> 15);
    rest = efe_pkg::FULL_W - frac;
    return efe_pkg::wgt_t'(efe_pkg::FULL_W - ((rest * rest) >> 15));
  endfunction

  function automatic efe_pkg::wgt_t envelope_weight();
    longint unsigned eased;
    longint unsigned from_w;
    if (env_exiting) begin
      if (len_out == '0) return '0;
      eased  = 64'(eased_fraction(env_elapsed, 64'(len_out)));
      from_w = 64'(env_fade_from);
      return efe_pkg::wgt_t'((from_w * (efe_pkg::FULL_W - eased)) >> 16);
    end
    if (len_in != '0 && env_elapsed < len_in)
      return eased_fraction(env_elapsed, 64'(len_in));
    return efe_pkg::FULL_W;
  endfunction

  function automatic void begin_fade(bit immediate);
    if (!env_active) return;
    if (immediate) begin
      env_active    = 1'b0;
      env_exiting   = 1'b0;
      env_weight    = '0;
      env_fade_from = efe_pkg::FULL_W;   // paused flag is left as it is
    end else begin
      env_fade_from = env_weight;
      env_exiting   = 1'b1;
      env_elapsed   = 0;
    end
  endfunction

  function automatic envelope_t envelope_step(efe_pkg::action_t act, efe_pkg::delta_t dt);
    envelope_t       res;
    longint unsigned sum;
    case (act)
      efe_pkg::ACT_TICK: begin
        if (env_active && !env_paused) begin
          sum = env_elapsed + dt;
          if (sum > efe_pkg::TIME_MAX) sum = 64'(efe_pkg::TIME_MAX);
          env_elapsed = sum;
          if (len_run != '0 && env_elapsed >= len_run && !env_exiting) begin_fade(1'b0);
          env_weight = envelope_weight();
        end
      end
      efe_pkg::ACT_ON: begin
        env_elapsed   = 0;
        env_active    = 1'b1;
        env_exiting   = 1'b0;
        env_paused    = 1'b0;
        env_fade_from = efe_pkg::FULL_W;
        env_weight    = '0;
      end
      efe_pkg::ACT_OFF: begin
        if (on_release == efe_pkg::EB_BLEND) begin_fade(1'b0);
        else if (on_release == efe_pkg::EB_END) begin_fade(1'b1);
      end
      efe_pkg::ACT_PAUSE:  env_paused = 1'b1;
      efe_pkg::ACT_RESUME: env_paused = 1'b0;
      default: ;
    endcase
    res.weight  = env_weight;
    res.active  = env_active;
    res.exiting = env_exiting;
    res.paused  = env_paused;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Shared helpers
  // --------------------------------------------------------------------------

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (!idling) return 0;
    roll = $urandom_range(99, 0);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: result %0d %s expected %0d got %0d",
                 $realtime, results_seen, field, want, got);
    end
  endtask

  // one item: optional gap, then hold valid until taken; valid is left high
  task automatic send_item(efe_pkg::action_t act, efe_pkg::delta_t dt);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.delta_time <= dt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_envelope.push_back(envelope_step(act, dt));
    items_sent++;
  endtask

  // stop sending and wait for every outstanding result, then let the back end settle
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_envelope.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // APB write with read-back; upper bits beyond the register width are dropped
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] keep;
    logic [31:0] got;
    keep = (idx == efe_pkg::REG_END_BEH) ? ((32'd1 << efe_pkg::EB_W) - 32'd1) :
           ((32'd1 << efe_pkg::CFG_W) - 32'd1);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      efe_pkg::REG_BLEND_IN:  len_in     = efe_pkg::cfgv_t'(value & keep);
      efe_pkg::REG_BLEND_OUT: len_out    = efe_pkg::cfgv_t'(value & keep);
      efe_pkg::REG_DURATION:  len_run    = efe_pkg::cfgv_t'(value & keep);
      efe_pkg::REG_END_BEH:   on_release = efe_pkg::eb_t'(value & keep);
      default: ;
    endcase
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    report_field("register read-back", value & keep, got);
  endtask

  // new setting while idle; random junk in the unused upper bits
  task automatic set_envelope_regs(efe_pkg::cfgv_t bin, efe_pkg::cfgv_t bout,
                                   efe_pkg::cfgv_t dur, efe_pkg::eb_t eb);
    wait_until_drained();
    write_reg(efe_pkg::REG_BLEND_IN,  {8'($urandom), bin});
    write_reg(efe_pkg::REG_BLEND_OUT, {8'($urandom), bout});
    write_reg(efe_pkg::REG_DURATION,  {8'($urandom), dur});
    write_reg(efe_pkg::REG_END_BEH,   {30'($urandom), eb});
    settings_used++;
  endtask

  function automatic efe_pkg::cfgv_t pick_len();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return CFG_MAX;
      2:       return efe_pkg::cfgv_t'($urandom_range(64, 1));
      default: return efe_pkg::cfgv_t'($urandom_range(20000, 65));
    endcase
  endfunction

  // tick sizes mostly in proportion to the programmed lengths
  function automatic efe_pkg::delta_t pick_delta(int unsigned scale);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 65) return efe_pkg::delta_t'($urandom_range(scale / 6 + 1, 0));
    if (roll < 80) return efe_pkg::delta_t'($urandom_range(255, 0));
    if (roll < 90) return efe_pkg::delta_t'($urandom);
    if (roll < 95) return '0;
    return DELTA_MAX;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker and result-side stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && sink_ready) begin
      results_seen++;
      if (expected_envelope.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %0d arrived with nothing expected", $realtime, results_seen);
      end else begin
        due = expected_envelope.pop_front();
        report_field("weight",     32'(due.weight),  32'(out_ch.weight));
        report_field("is_active",  32'(due.active),  32'(out_ch.is_active));
        report_field("is_exiting", 32'(due.exiting), 32'(out_ch.is_exiting));
        report_field("is_paused",  32'(due.paused),  32'(out_ch.is_paused));
      end
    end
    // ready for the next cycle
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold--;
      sink_ready <= 1'b0;
    end else begin
      sink_hold = idle_gap();
      if (sink_hold != 0) begin
        sink_hold--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // commands before activation, spare action codes, instant full weight
  task automatic test_inactive_commands();
    int a;
    set_envelope_regs('0, '0, '0, efe_pkg::EB_BLEND);
    send_item(efe_pkg::ACT_TICK, DELTA_MAX);     // ignored while inactive
    send_item(efe_pkg::ACT_OFF, DELTA_MAX);      // deactivate with nothing active
    send_item(efe_pkg::ACT_PAUSE, '0);           // only the paused flag moves
    send_item(efe_pkg::ACT_TICK, 16'h1234);
    send_item(efe_pkg::ACT_RESUME, '0);
    for (a = int'(ACT_SPARE_FIRST); a <= int'(ACT_SPARE_LAST); a++)
      send_item(efe_pkg::action_t'(a), DELTA_MAX);
    send_item(efe_pkg::ACT_ON, DELTA_MAX);
    send_item(efe_pkg::ACT_TICK, '0);            // zero blend-in: straight to full
  endtask

  // ease-in either side of the half point, pause, blend-back and its restart
  task automatic test_blend_curve();
    set_envelope_regs(efe_pkg::cfgv_t'(1000), efe_pkg::cfgv_t'(800),
                      efe_pkg::cfgv_t'(3000), efe_pkg::EB_BLEND);
    send_item(efe_pkg::ACT_ON, '0);
    send_item(efe_pkg::ACT_TICK, 16'd100);
    send_item(efe_pkg::ACT_TICK, 16'd400);
    send_item(efe_pkg::ACT_PAUSE, '0);
    send_item(efe_pkg::ACT_TICK, 16'd500);       // frozen
    send_item(efe_pkg::ACT_RESUME, '0);
    send_item(efe_pkg::ACT_TICK, 16'd600);       // past blend-in
    send_item(efe_pkg::ACT_OFF, '0);
    send_item(efe_pkg::ACT_TICK, 16'd200);
    send_item(efe_pkg::ACT_OFF, '0);             // restarts from the current weight
    send_item(efe_pkg::ACT_TICK, 16'd300);
    send_item(efe_pkg::ACT_TICK, 16'd1000);      // blend-out over, weight held at zero
    send_item(efe_pkg::ACT_TICK, DELTA_MAX);
    // duration expiry mid blend-in
    set_envelope_regs(efe_pkg::cfgv_t'(1000), efe_pkg::cfgv_t'(500),
                      efe_pkg::cfgv_t'(1500), efe_pkg::EB_BLEND);
    send_item(efe_pkg::ACT_ON, '0);
    send_item(efe_pkg::ACT_TICK, 16'd700);
    send_item(efe_pkg::ACT_TICK, 16'd900);
    send_item(efe_pkg::ACT_TICK, 16'd250);
    send_item(efe_pkg::ACT_TICK, 16'd300);
  endtask

  // immediate end keeps pause, stay and the spare code ignore deactivate
  task automatic test_end_behaviours();
    set_envelope_regs(efe_pkg::cfgv_t'(64), '0, '0, efe_pkg::EB_END);
    send_item(efe_pkg::ACT_ON, '0);
    send_item(efe_pkg::ACT_TICK, 16'd16);
    send_item(efe_pkg::ACT_PAUSE, '0);
    send_item(efe_pkg::ACT_OFF, '0);
    send_item(efe_pkg::ACT_TICK, 16'd10);
    set_envelope_regs(efe_pkg::cfgv_t'(64), efe_pkg::cfgv_t'(64), '0, EB_STAY);
    send_item(efe_pkg::ACT_ON, '0);
    send_item(efe_pkg::ACT_OFF, '0);
    send_item(efe_pkg::ACT_TICK, 16'd100);
    set_envelope_regs(efe_pkg::cfgv_t'(64), efe_pkg::cfgv_t'(64), '0, EB_SPARE);
    send_item(efe_pkg::ACT_OFF, '0);
    // zero blend-out: weight drops on the first tick after deactivate
    set_envelope_regs('0, '0, '0, efe_pkg::EB_BLEND);
    send_item(efe_pkg::ACT_ON, '0);
    send_item(efe_pkg::ACT_TICK, 16'd5);
    send_item(efe_pkg::ACT_OFF, '0);
    send_item(efe_pkg::ACT_TICK, 16'd1);
  endtask

  // longest lengths; enough full ticks to pin the timer at its ceiling
  task automatic test_timer_saturation();
    idling = 1'b0;
    set_envelope_regs(CFG_MAX, CFG_MAX, '0, efe_pkg::EB_BLEND);
    send_item(efe_pkg::ACT_ON, '0);
    repeat (258) send_item(efe_pkg::ACT_TICK, DELTA_MAX);
    send_item(efe_pkg::ACT_OFF, '0);
    repeat (4) send_item(efe_pkg::ACT_TICK, DELTA_MAX);
    idling = 1'b1;
  endtask

  // one envelope lifetime, random content, with some noise and sender holds
  task automatic run_session(int unsigned scale);
    int unsigned n;
    int unsigned roll;
    if ($urandom_range(9, 0) != 0) send_item(efe_pkg::ACT_ON, efe_pkg::delta_t'($urandom));
    n = $urandom_range(40, 4);
    repeat (n) begin
      roll = $urandom_range(99, 0);
      if (roll < 72)      send_item(efe_pkg::ACT_TICK, pick_delta(scale));
      else if (roll < 80) send_item(efe_pkg::ACT_OFF, efe_pkg::delta_t'($urandom));
      else if (roll < 85) send_item(efe_pkg::ACT_PAUSE, efe_pkg::delta_t'($urandom));
      else if (roll < 90) send_item(efe_pkg::ACT_RESUME, efe_pkg::delta_t'($urandom));
      else if (roll < 93) send_item(efe_pkg::ACT_ON, efe_pkg::delta_t'($urandom));
      else if (roll < 96)
        send_item(efe_pkg::action_t'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST)),
                  efe_pkg::delta_t'($urandom));
      else if (roll < 99)
        send_item(efe_pkg::action_t'($urandom), efe_pkg::delta_t'($urandom));
      else wait_until_drained();
    end
  endtask

  task automatic test_random_traffic();
    int             phase;
    int unsigned    target;
    int unsigned    scale;
    efe_pkg::cfgv_t bin;
    efe_pkg::cfgv_t bout;
    efe_pkg::cfgv_t dur;
    efe_pkg::eb_t   eb;
    for (phase = 0; phase < 8; phase++) begin
      // every third phase runs flat out on both sides
      idling = (phase % 3 != 2);
      if (phase == 0) begin
        bin = CFG_MAX; bout = CFG_MAX; dur = CFG_MAX; eb = efe_pkg::EB_BLEND;
      end else if (phase == 1) begin
        bin = '0; bout = '0; dur = efe_pkg::cfgv_t'(1); eb = efe_pkg::EB_END;
      end else begin
        bin  = pick_len();
        bout = pick_len();
        dur  = pick_len();
        eb   = (phase < 6) ? efe_pkg::EB_BLEND : efe_pkg::eb_t'($urandom_range(3, 0));
      end
      set_envelope_regs(bin, bout, dur, eb);
      scale = 256;
      if (bin  != '0 && bin  > scale) scale = 32'(bin);
      if (bout != '0 && bout > scale) scale = 32'(bout);
      if (dur  != '0 && dur  > scale) scale = 32'(dur);
      if (scale > DELTA_MAX) scale = 32'(DELTA_MAX);
      target = items_sent + 200;
      while (items_sent < target) run_session(scale);
    end
    idling = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = efe_pkg::ACT_TICK;
    in_ch.delta_time = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    items_sent       = 0;
    results_seen     = 0;
    mismatches       = 0;
    settings_used    = 0;
    sink_hold        = 0;
    reset_envelope_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_inactive_commands();
    test_blend_curve();
    test_end_behaviours();
    test_timer_saturation();
    test_random_traffic();

    // every result in, then a quiet spell to catch stray ones
    wait_until_drained();
    $display("Sent %0d items (idle commands, easing, end modes, timer ceiling, random)",
             items_sent);
    $display("across %0d register settings; %0d results compared.",
             settings_used, results_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
